/* hdl/assert_macros.svh */
// Assertion macros shared by the line/circle intersection RTL.
// Needs clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hdl/clp_pkg.sv */
// Shared widths, word types and helpers for the line/circle intersection block.
// No dependencies.
package clp_pkg;

  localparam int COORD_W = 32;
  localparam int DIFF_W  = COORD_W + 1;        // P and D components
  localparam int QUAD_W  = 2 * COORD_W + 2;    // a, h, c
  localparam int DISC_W  = 4 * COORD_W + 5;    // quarter discriminant, signed
  localparam int RAD_W   = 4 * COORD_W + 4;    // root unit input
  localparam int ROOT_W  = RAD_W / 2;
  localparam int FAC_W   = 2 * COORD_W + 4;    // -h +/- s
  localparam int NUM_W   = FAC_W + DIFF_W;     // D * factor
  localparam int MUL_CHUNK = 16;

  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic signed [COORD_W-1:0] centre_x;
    logic signed [COORD_W-1:0] centre_y;
    logic        [COORD_W-2:0] radius;
  } in_word_t;

  typedef struct packed {
    logic                      hit;
    logic signed [COORD_W-1:0] first_x;
    logic signed [COORD_W-1:0] first_y;
    logic signed [COORD_W-1:0] second_x;
    logic signed [COORD_W-1:0] second_y;
  } out_word_t;

  // stages of the chunked multiplier for a multiplier operand of wb bits
  function automatic int mul_lat(input int wb);
    return (wb + MUL_CHUNK - 1) / MUL_CHUNK;
  endfunction

endpackage

/* hdl/circle_line_intersection.sv */
// Top level of the line/circle intersection pipeline.
// Depends on clp_pkg, clp_mul, clp_sqrt, clp_div, clp_dly and assert_macros.svh.
`include "assert_macros.svh"

// Fully pipelined: a word is taken on every clock where start is high and busy
// is low, and its result shows on out_word with out_valid for exactly one
// cycle. The depth is set by the bit-per-stage square root of the 132-bit
// discriminant (66 stages) and the bit-per-stage floor dividers (35 stages).
// Results cannot be held off, so nothing ever stalls; busy is only high while
// in reset and the cycle after.
// hit is 1 only when the line crosses the circle at two points; for a miss,
// a tangent line or a line whose two points coincide, hit and all four
// coordinates are zero. first_* is the crossing with the smaller line
// parameter. Coordinates are Q16.16; results saturate to the 32-bit range.
module circle_line_intersection
  import clp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  output logic      out_valid,
  output out_word_t out_word
);

  localparam int L1  = mul_lat(DIFF_W);   // D/P products
  localparam int L2  = mul_lat(QUAD_W);   // h*h, a*c
  localparam int LS  = ROOT_W;            // square root
  localparam int L3  = mul_lat(DIFF_W);   // D * factor
  localparam int LD  = COORD_W + 3;       // divider
  localparam int N_D = L1 + L2 + LS + 3;
  localparam int N_S = N_D + L3;
  localparam int N_A = L2 + LS + 2 + L3;
  localparam int N_H = L2 + LS + 1;
  localparam int N_HIT = LS + 1 + L3 + LD;
  localparam int LAT = 6 + L1 + L2 + LS + L3 + LD;

  // ---- handshake ----
  logic busy_r;
  logic accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  // ---- stage 0: capture input word ----
  logic     in_v_r;
  in_word_t in_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    in_r <= in_word;
  end

  // ---- stage 1: translate so the centre is the origin ----
  function automatic logic [DIFF_W-1:0] dif(input logic [COORD_W-1:0] x,
                                            input logic [COORD_W-1:0] y);
    return {x[COORD_W-1], x} - {y[COORD_W-1], y};
  endfunction

  logic                      v1_r;
  logic signed [DIFF_W-1:0]  px_r, py_r, dx_r, dy_r, rq_r;
  logic        [COORD_W-1:0] sx_r, sy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    px_r <= dif(in_r.start_x, in_r.centre_x);
    py_r <= dif(in_r.start_y, in_r.centre_y);
    dx_r <= dif(in_r.end_x, in_r.start_x);
    dy_r <= dif(in_r.end_y, in_r.start_y);
    rq_r <= {2'b00, in_r.radius};
    sx_r <= in_r.start_x;
    sy_r <= in_r.start_y;
  end

  // ---- first products ----
  logic              m1_v;
  logic [QUAD_W-1:0] xx, yy, xp, yp, ppx, ppy, rr;

  clp_mul #(.WA(DIFF_W), .WB(DIFF_W)) u_mul_xx (
    .clk, .rst_n, .in_v(v1_r), .in_a(dx_r), .in_b(dx_r), .out_v(m1_v), .out_p(xx));
  clp_mul #(.WA(DIFF_W), .WB(DIFF_W)) u_mul_yy (
    .clk, .rst_n, .in_v(v1_r), .in_a(dy_r), .in_b(dy_r), .out_v(), .out_p(yy));
  clp_mul #(.WA(DIFF_W), .WB(DIFF_W)) u_mul_xp (
    .clk, .rst_n, .in_v(v1_r), .in_a(dx_r), .in_b(px_r), .out_v(), .out_p(xp));
  clp_mul #(.WA(DIFF_W), .WB(DIFF_W)) u_mul_yp (
    .clk, .rst_n, .in_v(v1_r), .in_a(dy_r), .in_b(py_r), .out_v(), .out_p(yp));
  clp_mul #(.WA(DIFF_W), .WB(DIFF_W)) u_mul_ppx (
    .clk, .rst_n, .in_v(v1_r), .in_a(px_r), .in_b(px_r), .out_v(), .out_p(ppx));
  clp_mul #(.WA(DIFF_W), .WB(DIFF_W)) u_mul_ppy (
    .clk, .rst_n, .in_v(v1_r), .in_a(py_r), .in_b(py_r), .out_v(), .out_p(ppy));
  clp_mul #(.WA(DIFF_W), .WB(DIFF_W)) u_mul_rr (
    .clk, .rst_n, .in_v(v1_r), .in_a(rq_r), .in_b(rq_r), .out_v(), .out_p(rr));

  // ---- stage 2: quadratic coefficients (h is half of the usual b) ----
  logic              v2_r;
  logic [QUAD_W-1:0] a_r, h_r, c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= m1_v;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= xx + yy;
    h_r <= xp + yp;
    c_r <= ppx + ppy - rr;
  end

  // ---- discriminant products ----
  logic                m2_v;
  logic [2*QUAD_W-1:0] hh, ac;

  clp_mul #(.WA(QUAD_W), .WB(QUAD_W)) u_mul_hh (
    .clk, .rst_n, .in_v(v2_r), .in_a(h_r), .in_b(h_r), .out_v(m2_v), .out_p(hh));
  clp_mul #(.WA(QUAD_W), .WB(QUAD_W)) u_mul_ac (
    .clk, .rst_n, .in_v(v2_r), .in_a(a_r), .in_b(c_r), .out_v(), .out_p(ac));

  // ---- stage 3: quarter discriminant and hit decision ----
  logic [DISC_W-1:0] q;
  logic              q_pos;
  logic              v3_r, hit_r;
  logic [RAD_W-1:0]  rad_r;

  assign q     = {hh[2*QUAD_W-1], hh} - {ac[2*QUAD_W-1], ac};
  assign q_pos = !q[DISC_W-1] && (q != '0);   // a == 0 forces q == 0

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= m2_v;
    end
  end

  always_ff @(posedge clk) begin
    hit_r <= q_pos;
    rad_r <= q_pos ? q[RAD_W-1:0] : '0;
  end

  // ---- square root ----
  logic              sq_v;
  logic [ROOT_W-1:0] s;

  clp_sqrt #(.WI(RAD_W)) u_sqrt (
    .clk, .rst_n, .in_v(v3_r), .in_x(rad_r), .out_v(sq_v), .out_s(s));

  // ---- stage 4: parameter numerators -h - s and -h + s ----
  logic [QUAD_W-1:0]       h_d;
  logic signed [FAC_W-1:0] hx, sxt;
  logic                    v4_r;
  logic signed [FAC_W-1:0] f1_r, f2_r;

  clp_dly #(.W(QUAD_W), .N(N_H)) u_dly_h (.clk, .d(h_r), .q(h_d));

  assign hx  = {{(FAC_W-QUAD_W){h_d[QUAD_W-1]}}, h_d};
  assign sxt = {{(FAC_W-ROOT_W){1'b0}}, s};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    f1_r <= -hx - sxt;
    f2_r <= sxt - hx;
  end

  // ---- direction times numerator ----
  logic [2*DIFF_W-1:0] d_d;
  logic [DIFF_W-1:0]   dxd, dyd;
  logic                m3_v;
  logic [NUM_W-1:0]    n1x, n1y, n2x, n2y;

  clp_dly #(.W(2*DIFF_W), .N(N_D)) u_dly_d (.clk, .d({dx_r, dy_r}), .q(d_d));

  assign dxd = d_d[2*DIFF_W-1:DIFF_W];
  assign dyd = d_d[DIFF_W-1:0];

  clp_mul #(.WA(FAC_W), .WB(DIFF_W)) u_mul_n1x (
    .clk, .rst_n, .in_v(v4_r), .in_a(f1_r), .in_b(dxd), .out_v(m3_v), .out_p(n1x));
  clp_mul #(.WA(FAC_W), .WB(DIFF_W)) u_mul_n1y (
    .clk, .rst_n, .in_v(v4_r), .in_a(f1_r), .in_b(dyd), .out_v(), .out_p(n1y));
  clp_mul #(.WA(FAC_W), .WB(DIFF_W)) u_mul_n2x (
    .clk, .rst_n, .in_v(v4_r), .in_a(f2_r), .in_b(dxd), .out_v(), .out_p(n2x));
  clp_mul #(.WA(FAC_W), .WB(DIFF_W)) u_mul_n2y (
    .clk, .rst_n, .in_v(v4_r), .in_a(f2_r), .in_b(dyd), .out_v(), .out_p(n2y));

  // ---- divide by a, add start point, saturate ----
  logic [QUAD_W-1:0]    a_d;
  logic [2*COORD_W-1:0] s_d;
  logic                 dv_v;
  logic [COORD_W-1:0]   p1x, p1y, p2x, p2y;

  clp_dly #(.W(QUAD_W), .N(N_A)) u_dly_a (.clk, .d(a_r), .q(a_d));
  clp_dly #(.W(2*COORD_W), .N(N_S)) u_dly_s (.clk, .d({sx_r, sy_r}), .q(s_d));

  clp_div #(.CW(COORD_W), .WN(NUM_W), .WK(QUAD_W)) u_div_1x (
    .clk, .rst_n, .in_v(m3_v), .in_n(n1x), .in_d(a_d),
    .in_s0(s_d[2*COORD_W-1:COORD_W]), .out_v(dv_v), .out_c(p1x));
  clp_div #(.CW(COORD_W), .WN(NUM_W), .WK(QUAD_W)) u_div_1y (
    .clk, .rst_n, .in_v(m3_v), .in_n(n1y), .in_d(a_d),
    .in_s0(s_d[COORD_W-1:0]), .out_v(), .out_c(p1y));
  clp_div #(.CW(COORD_W), .WN(NUM_W), .WK(QUAD_W)) u_div_2x (
    .clk, .rst_n, .in_v(m3_v), .in_n(n2x), .in_d(a_d),
    .in_s0(s_d[2*COORD_W-1:COORD_W]), .out_v(), .out_c(p2x));
  clp_div #(.CW(COORD_W), .WN(NUM_W), .WK(QUAD_W)) u_div_2y (
    .clk, .rst_n, .in_v(m3_v), .in_n(n2y), .in_d(a_d),
    .in_s0(s_d[COORD_W-1:0]), .out_v(), .out_c(p2y));

  // ---- output register; a miss zeroes every field ----
  logic      hit_d;
  logic      out_valid_r;
  out_word_t out_word_r;
  logic      out_zero;

  clp_dly #(.W(1), .N(N_HIT)) u_dly_hit (.clk, .d(hit_r), .q(hit_d));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r.hit      <= hit_d;
    out_word_r.first_x  <= hit_d ? p1x : '0;
    out_word_r.first_y  <= hit_d ? p1y : '0;
    out_word_r.second_x <= hit_d ? p2x : '0;
    out_word_r.second_y <= hit_d ? p2y : '0;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign out_zero = (out_word.first_x == '0) && (out_word.first_y == '0)
                 && (out_word.second_x == '0) && (out_word.second_y == '0);

  `ASSERT_IMPL(a_fixed_latency, out_valid, $past(start && !busy, LAT))
  `ASSERT_IMPL(a_miss_is_zero, out_valid && !out_word.hit, out_zero)

endmodule

/* hdl/clp_dly.sv */
// Fixed-length register delay line for pipeline sideband data.
// No dependencies.
module clp_dly #(
  parameter int W = 8,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr_r [N];

  always_ff @(posedge clk) begin
    sr_r[0] <= d;
    for (int i = 1; i < N; i++) begin
      sr_r[i] <= sr_r[i-1];
    end
  end

  assign q = sr_r[N-1];

endmodule

/* hdl/clp_mul.sv */
// Pipelined signed multiplier, one MUL_CHUNK-bit slice of operand b per stage.
// Depends on clp_pkg.
module clp_mul
  import clp_pkg::*;
#(
  parameter int WA = 33,
  parameter int WB = 33
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_v,
  input  logic signed [WA-1:0]    in_a,
  input  logic signed [WB-1:0]    in_b,
  output logic                    out_v,
  output logic signed [WA+WB-1:0] out_p
);

  localparam int NCH = mul_lat(WB);
  localparam int WP  = WA + WB;

  logic                 v_r   [NCH];
  logic signed [WA-1:0] a_r   [NCH];
  logic signed [WB-1:0] b_r   [NCH];
  logic signed [WP-1:0] acc_r [NCH];

  for (genvar k = 0; k < NCH; k++) begin : g_st
    localparam int LO = MUL_CHUNK * k;
    localparam int CW = (k == NCH - 1) ? (WB - LO) : MUL_CHUNK;
    logic                 v_s;
    logic signed [WA-1:0] a_s;
    logic signed [WB-1:0] b_s;
    logic signed [WP-1:0] acc_s;
    logic signed [CW:0]   chunk_s;
    logic signed [WA+CW:0] pp_s;
    logic signed [WP-1:0] acc_nxt;

    if (k == 0) begin : g_first
      assign v_s   = in_v;
      assign a_s   = in_a;
      assign b_s   = in_b;
      assign acc_s = '0;
    end else begin : g_next
      assign v_s   = v_r[k-1];
      assign a_s   = a_r[k-1];
      assign b_s   = b_r[k-1];
      assign acc_s = acc_r[k-1];
    end

    // top slice carries the sign, lower slices are unsigned
    if (k == NCH - 1) begin : g_top
      assign chunk_s = {b_s[WB-1], b_s[WB-1 -: CW]};
    end else begin : g_low
      assign chunk_s = {1'b0, b_s[LO +: CW]};
    end

    assign pp_s    = a_s * chunk_s;
    assign acc_nxt = acc_s + (WP'(pp_s) <<< LO);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_s;
      end
    end

    always_ff @(posedge clk) begin
      acc_r[k] <= acc_nxt;
      a_r[k]   <= a_s;
      b_r[k]   <= b_s;
    end
  end

  assign out_v = v_r[NCH-1];
  assign out_p = acc_r[NCH-1];

endmodule

/* hdl/clp_sqrt.sv */
// Pipelined integer square root, one root bit per stage (floor result).
// No dependencies.
module clp_sqrt #(
  parameter int WI = 132
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_v,
  input  logic [WI-1:0]   in_x,
  output logic            out_v,
  output logic [WI/2-1:0] out_s
);

  localparam int WO = WI / 2;

  logic          v_r    [WO];
  logic [WI-1:0] x_r    [WO];
  logic [WO:0]   rem_r  [WO];
  logic [WO-1:0] root_r [WO];

  for (genvar k = 0; k < WO; k++) begin : g_st
    logic          v_s;
    logic [WI-1:0] x_s;
    logic [WO:0]   rem_s;
    logic [WO-1:0] root_s;
    logic [WO+2:0] rsh;
    logic [WO+2:0] trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign v_s    = in_v;
      assign x_s    = in_x;
      assign rem_s  = '0;
      assign root_s = '0;
    end else begin : g_next
      assign v_s    = v_r[k-1];
      assign x_s    = x_r[k-1];
      assign rem_s  = rem_r[k-1];
      assign root_s = root_r[k-1];
    end

    assign rsh   = {rem_s, x_s[WI-1 -: 2]};
    assign trial = {1'b0, root_s, 2'b01};
    assign ge    = rsh >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_s;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k]  <= ge ? (WO+1)'(rsh - trial) : rsh[WO:0];
      root_r[k] <= {root_s[WO-2:0], ge};
      x_r[k]    <= {x_s[WI-3:0], 2'b00};
    end
  end

  assign out_v = v_r[WO-1];
  assign out_s = root_r[WO-1];

endmodule

/* hdl/clp_div.sv */
// Pipelined floor division of the point offset by a, plus start and saturation.
// One quotient bit per stage; includes assert_macros.svh.
`include "assert_macros.svh"
module clp_div #(
  parameter int CW = 32,
  parameter int WN = 101,
  parameter int WK = 66
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_v,
  input  logic signed [WN-1:0] in_n,
  input  logic        [WK-1:0] in_d,
  input  logic signed [CW-1:0] in_s0,
  output logic                 out_v,
  output logic signed [CW-1:0] out_c
);

  localparam int NST = CW + 1;
  localparam logic signed [CW+2:0] SUM_HI = {4'b0000, {(CW-1){1'b1}}};
  localparam logic signed [CW+2:0] SUM_LO = {4'b1111, {(CW-1){1'b0}}};
  localparam logic [CW-1:0] SAT_HI = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] SAT_LO = {1'b1, {(CW-1){1'b0}}};

  // pre stage: magnitude and overflow check (quotient needs more than CW+1 bits)
  logic [WN-1:0] mag;
  logic [WN-1:0] lim;

  logic          pv_r;
  logic          pneg_r, pbig_r;
  logic [WK-1:0] prem_r, pd_r;
  logic [CW:0]   plow_r;
  logic [CW-1:0] ps0_r;

  assign mag = in_n[WN-1] ? WN'(-in_n) : WN'(in_n);
  assign lim = WN'({in_d, {(CW+1){1'b0}}});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    pneg_r <= in_n[WN-1];
    pbig_r <= mag >= lim;
    prem_r <= mag[CW+1 +: WK];
    plow_r <= mag[CW:0];
    pd_r   <= in_d;
    ps0_r  <= in_s0;
  end

  logic          st_v_r [NST];
  logic          neg_r  [NST];
  logic          big_r  [NST];
  logic [WK-1:0] rem_r  [NST];
  logic [WK-1:0] d_r    [NST];
  logic [CW:0]   low_r  [NST];
  logic [CW-1:0] s0_r   [NST];

  for (genvar k = 0; k < NST; k++) begin : g_st
    logic          v_s, neg_s, big_s;
    logic [WK-1:0] rem_s, d_s;
    logic [CW:0]   low_s;
    logic [CW-1:0] s0_s;
    logic [WK:0]   rsh;
    logic          ge;

    if (k == 0) begin : g_first
      assign v_s   = pv_r;
      assign neg_s = pneg_r;
      assign big_s = pbig_r;
      assign rem_s = prem_r;
      assign d_s   = pd_r;
      assign low_s = plow_r;
      assign s0_s  = ps0_r;
    end else begin : g_next
      assign v_s   = st_v_r[k-1];
      assign neg_s = neg_r[k-1];
      assign big_s = big_r[k-1];
      assign rem_s = rem_r[k-1];
      assign d_s   = d_r[k-1];
      assign low_s = low_r[k-1];
      assign s0_s  = s0_r[k-1];
    end

    assign rsh = {rem_s, low_s[CW]};
    assign ge  = rsh >= {1'b0, d_s};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_v_r[k] <= 1'b0;
      end else begin
        st_v_r[k] <= v_s;
      end
    end

    // low bits shift out into the remainder, quotient bits shift in
    always_ff @(posedge clk) begin
      rem_r[k] <= ge ? WK'(rsh - {1'b0, d_s}) : rsh[WK-1:0];
      low_r[k] <= {low_s[CW-1:0], ge};
      neg_r[k] <= neg_s;
      big_r[k] <= big_s;
      d_r[k]   <= d_s;
      s0_r[k]  <= s0_s;
    end
  end

  // final stage: round toward minus infinity, add start, saturate
  logic [CW+1:0]        qm;
  logic signed [CW+2:0] val;
  logic signed [CW+2:0] sum;
  logic [CW-1:0]        c_nxt;
  logic                 out_v_r;
  logic [CW-1:0]        out_c_r;

  assign qm  = {1'b0, low_r[NST-1]}
             + (CW+2)'(neg_r[NST-1] && (rem_r[NST-1] != '0));
  assign val = neg_r[NST-1] ? -{1'b0, qm} : {1'b0, qm};
  assign sum = val + {{3{s0_r[NST-1][CW-1]}}, s0_r[NST-1]};

  always_comb begin
    if (big_r[NST-1]) begin
      c_nxt = neg_r[NST-1] ? SAT_LO : SAT_HI;
    end else if (sum > SUM_HI) begin
      c_nxt = SAT_HI;
    end else if (sum < SUM_LO) begin
      c_nxt = SAT_LO;
    end else begin
      c_nxt = sum[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= st_v_r[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    out_c_r <= c_nxt;
  end

  assign out_v = out_v_r;
  assign out_c = out_c_r;

  `ASSERT_IMPL(a_rem_below_divisor, st_v_r[NST-1] && !big_r[NST-1], rem_r[NST-1] < d_r[NST-1])

endmodule
